>>> sv/envelope_auto_wah_core_assert.svh
// Assertion macros for the auto-wah core.
// Clocked on clk; the first form is disabled while rst is high.
`ifndef ENVELOPE_AUTO_WAH_CORE_ASSERT_SVH
`define ENVELOPE_AUTO_WAH_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define EAW_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("auto-wah core assertion failed");
`define EAW_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("auto-wah core assertion failed");
`else
`define EAW_ASSERT(lbl, prop)
`define EAW_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

>>> sv/eaw_pkg.sv
`timescale 1ns / 1ps
package eaw_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_FRAC_BITS = 28;
  localparam int CORDIC_MAX     = 28;
  localparam int ROUND_SHIFT    = 30 - COEF_FRAC_BITS;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  typedef enum logic [4:0] {
    ST_IDLE, ST_ENV_M0, ST_ENV_M1, ST_ENV_ADD, ST_FC_M, ST_FC_ADD,
    ST_DIV_START, ST_DIV, ST_DIV_DONE, ST_CORDIC, ST_TRIG,
    ST_FIR_M0, ST_FIR_M1, ST_FIR_M2, ST_FIR_M3, ST_FIR_SUM, ST_FIR_Y,
    ST_MIX_M0, ST_MIX_M1, ST_MIX_ADD
  } state_t;

  typedef enum logic [2:0] {
    DK_TURN, DK_ALPHA, DK_B0, DK_A1, DK_A2
  } div_kind_t;

  typedef enum logic [2:0] {
    REG_ATTACK, REG_RELEASE, REG_MIN_CUTOFF, REG_MAX_CUTOFF,
    REG_QUALITY, REG_WET_MIX, REG_SAMPLE_RATE
  } reg_index_t;

  // atan(2^-i) in turns, Q0.32
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

>>> sv/eaw_in_if.sv
`timescale 1ns / 1ps
interface eaw_in_if;
  logic                                       valid;
  logic                                       ready;
  logic signed [eaw_pkg::SAMPLE_BITS-1:0]     dry_sample;

  modport source (output valid, output dry_sample, input ready);
  modport sink   (input valid, input dry_sample, output ready);
endinterface

>>> sv/eaw_out_if.sv
`timescale 1ns / 1ps
interface eaw_out_if;
  logic                                       valid;
  logic                                       ready;
  logic signed [eaw_pkg::SAMPLE_BITS-1:0]     mixed_sample;

  modport source (output valid, output mixed_sample, input ready);
  modport sink   (input valid, input mixed_sample, output ready);
endinterface

>>> sv/envelope_auto_wah_core.sv
`timescale 1ns / 1ps
// Auto-wah core: each signed Q1.23 request on the audio channel updates a peak
// envelope (attack/release one-pole), maps it to a bandpass centre frequency,
// rebuilds the constant-skirt biquad coefficients (CORDIC sine/cosine, alpha,
// normalization by a0), filters the sample and blends dry and wet into one
// saturated request on the blend channel. All arithmetic runs on one registered
// 33x33 multiplier, one radix-2 restoring divider and one CORDIC shift-add
// stage under a sequencer. Between acceptance and the core being ready again
// a sample runs through five 64-step divisions (phase, alpha, b0, a1, a2)
// and the CORDIC rotation. The finished sample sits in an output register,
// so the next request can be taken while the blend channel is stalled.
// Configuration writes go straight to the registers and are read by every
// later step that uses them, including steps of a sample already in flight.
`include "envelope_auto_wah_core_assert.svh"
module envelope_auto_wah_core #(
  parameter int CORDIC_STEPS = 18
) (
  input  logic              clk,
  input  logic              rst,
  eaw_in_if.sink            audio,
  eaw_out_if.source         blend,
  input  logic              cfg_write,
  input  logic [2:0]        cfg_index,
  input  logic [17:0]       cfg_data
);

  localparam int SB = eaw_pkg::SAMPLE_BITS;
  localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic [IW-1:0] ITER_LAST = IW'(CORDIC_STEPS - 1);
  localparam logic [5:0] DIV_LAST = 6'd63;
  localparam logic [SB-1:0] ENV_ONE = SB'(1) << (SB - 1);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [15:0] attack_coef, release_coef, quality_q8;
  logic [16:0] min_cutoff_hz, max_cutoff_hz, wet_mix;
  logic [17:0] sample_rate_hz;

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_coef    <= 16'd65399;
      release_coef   <= 16'd65508;
      min_cutoff_hz  <= 17'd500;
      max_cutoff_hz  <= 17'd3000;
      quality_q8     <= 16'd512;
      wet_mix        <= 17'd52429;
      sample_rate_hz <= 18'd48000;
    end else if (cfg_write) begin
      case (cfg_index)
        eaw_pkg::REG_ATTACK:      attack_coef    <= cfg_data[15:0];
        eaw_pkg::REG_RELEASE:     release_coef   <= cfg_data[15:0];
        eaw_pkg::REG_MIN_CUTOFF:  min_cutoff_hz  <= cfg_data[16:0];
        eaw_pkg::REG_MAX_CUTOFF:  max_cutoff_hz  <= cfg_data[16:0];
        eaw_pkg::REG_QUALITY:     quality_q8     <= cfg_data[15:0];
        eaw_pkg::REG_WET_MIX:     wet_mix        <= cfg_data[16:0];
        eaw_pkg::REG_SAMPLE_RATE: sample_rate_hz <= cfg_data;
        default: ;
      endcase
    end
  end

  // Register clean-up: max raised to min, rate floor of one, Q floor of 0.1,
  // mix capped at fully wet.
  logic [16:0] fmax, fdiff, mix_eff;
  logic [17:0] fs_eff;
  logic [15:0] q8_eff;
  assign fmax    = (max_cutoff_hz < min_cutoff_hz) ? min_cutoff_hz : max_cutoff_hz;
  assign fdiff   = fmax - min_cutoff_hz;
  assign fs_eff  = (sample_rate_hz == 18'd0) ? 18'd1 : sample_rate_hz;
  assign q8_eff  = (quality_q8 < 16'd26) ? 16'd26 : quality_q8;
  assign mix_eff = (wet_mix > 17'd65536) ? 17'd65536 : wet_mix;

  // ---------------------------------------------------------------------------
  // datapath registers
  // ---------------------------------------------------------------------------
  eaw_pkg::state_t    state, state_next;
  eaw_pkg::div_kind_t div_kind;

  logic signed [SB-1:0] x, x1, x2;
  logic        [SB-1:0] env, mag;
  logic signed [31:0]   y1, y2, yv;
  logic        [15:0]   coef_sel;
  logic        [33:0]   fc;

  logic signed [32:0]   mul_a, mul_b;
  logic signed [65:0]   prod, acc;

  logic signed [33:0]   cx, cy, cz;
  logic        [IW-1:0] iter;
  logic                 trig_neg;
  logic signed [31:0]   cs, sn, alpha, b0, a1, a2;
  logic signed [32:0]   a0;

  logic [31:0] div_rem, div_den;
  logic [63:0] div_quo;
  logic        div_neg;
  logic [5:0]  div_cnt;

  logic                 out_valid;
  logic signed [SB-1:0] out_sample;

  assign mag      = x[SB-1] ? (~x + SB'(1)) : x;
  assign coef_sel = (mag > env) ? attack_coef : release_coef;

  // ---------------------------------------------------------------------------
  // next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      eaw_pkg::ST_IDLE:      if (audio.valid) state_next = eaw_pkg::ST_ENV_M0;
      eaw_pkg::ST_ENV_M0:    state_next = eaw_pkg::ST_ENV_M1;
      eaw_pkg::ST_ENV_M1:    state_next = eaw_pkg::ST_ENV_ADD;
      eaw_pkg::ST_ENV_ADD:   state_next = eaw_pkg::ST_FC_M;
      eaw_pkg::ST_FC_M:      state_next = eaw_pkg::ST_FC_ADD;
      eaw_pkg::ST_FC_ADD:    state_next = eaw_pkg::ST_DIV_START;
      eaw_pkg::ST_DIV_START: state_next = eaw_pkg::ST_DIV;
      eaw_pkg::ST_DIV:       if (div_cnt == DIV_LAST) state_next = eaw_pkg::ST_DIV_DONE;
      eaw_pkg::ST_DIV_DONE: begin
        case (div_kind)
          eaw_pkg::DK_TURN: state_next = eaw_pkg::ST_CORDIC;
          eaw_pkg::DK_A2:   state_next = eaw_pkg::ST_FIR_M0;
          default:          state_next = eaw_pkg::ST_DIV_START;
        endcase
      end
      eaw_pkg::ST_CORDIC:    if (iter == ITER_LAST) state_next = eaw_pkg::ST_TRIG;
      eaw_pkg::ST_TRIG:      state_next = eaw_pkg::ST_DIV_START;
      eaw_pkg::ST_FIR_M0:    state_next = eaw_pkg::ST_FIR_M1;
      eaw_pkg::ST_FIR_M1:    state_next = eaw_pkg::ST_FIR_M2;
      eaw_pkg::ST_FIR_M2:    state_next = eaw_pkg::ST_FIR_M3;
      eaw_pkg::ST_FIR_M3:    state_next = eaw_pkg::ST_FIR_SUM;
      eaw_pkg::ST_FIR_SUM:   state_next = eaw_pkg::ST_FIR_Y;
      eaw_pkg::ST_FIR_Y:     state_next = eaw_pkg::ST_MIX_M0;
      eaw_pkg::ST_MIX_M0:    state_next = eaw_pkg::ST_MIX_M1;
      eaw_pkg::ST_MIX_M1:    state_next = eaw_pkg::ST_MIX_ADD;
      eaw_pkg::ST_MIX_ADD:   if (!out_valid || blend.ready) state_next = eaw_pkg::ST_IDLE;
      default:               state_next = eaw_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= eaw_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // ---------------------------------------------------------------------------
  // outputs of the sequencer: ready, multiplier operands, divider operands
  // ---------------------------------------------------------------------------
  logic signed [63:0] dnum;
  logic signed [32:0] dden;
  logic signed [32:0] one_minus_alpha;
  assign one_minus_alpha = 33'sd268435456 - 33'(alpha);

  always_comb begin
    audio.ready = (state == eaw_pkg::ST_IDLE);
    mul_a = '0;
    mul_b = '0;
    case (state)
      eaw_pkg::ST_ENV_M0: begin
        mul_a = 33'(coef_sel);
        mul_b = 33'(env);
      end
      eaw_pkg::ST_ENV_M1: begin
        mul_a = 33'(17'd65536 - 17'(coef_sel));
        mul_b = 33'(mag);
      end
      eaw_pkg::ST_FC_M: begin
        mul_a = 33'(fdiff);
        mul_b = 33'(env);
      end
      eaw_pkg::ST_FIR_M0: begin
        mul_a = 33'(b0);
        mul_b = 33'(x);
      end
      eaw_pkg::ST_FIR_M1: begin
        mul_a = -33'(b0);
        mul_b = 33'(x2);
      end
      eaw_pkg::ST_FIR_M2: begin
        mul_a = -33'(a1);
        mul_b = 33'(y1);
      end
      eaw_pkg::ST_FIR_M3: begin
        mul_a = -33'(a2);
        mul_b = 33'(y2);
      end
      eaw_pkg::ST_MIX_M0: begin
        mul_a = 33'(17'd65536 - mix_eff);
        mul_b = 33'(x);
      end
      // wet product is held while the blend register is still occupied
      eaw_pkg::ST_MIX_M1, eaw_pkg::ST_MIX_ADD: begin
        mul_a = 33'(mix_eff);
        mul_b = 33'(yv);
      end
      default: ;
    endcase

    // dividend and divisor for the next division
    case (div_kind)
      eaw_pkg::DK_ALPHA: begin
        dnum = {{25{sn[31]}}, sn, 7'b0};
        dden = 33'(q8_eff);
      end
      eaw_pkg::DK_B0: begin
        dnum = {{5{sn[31]}}, sn, 27'b0};
        dden = a0;
      end
      eaw_pkg::DK_A1: begin
        dnum = -{{3{cs[31]}}, cs, 29'b0};
        dden = a0;
      end
      eaw_pkg::DK_A2: begin
        dnum = {{3{one_minus_alpha[32]}}, one_minus_alpha, 28'b0};
        dden = a0;
      end
      default: begin
        dnum = {14'b0, fc, 16'b0};
        dden = 33'(fs_eff);
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // shared units
  // ---------------------------------------------------------------------------
  // multiplier, one registered product per cycle
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // restoring divider step
  logic [32:0] div_trial;
  logic        div_fits;
  logic [31:0] div_rem_next;
  assign div_trial    = {div_rem, div_quo[63]};
  assign div_fits     = div_trial >= {1'b0, div_den};
  assign div_rem_next = div_fits ? 32'(div_trial - {1'b0, div_den}) : div_trial[31:0];

  // quotient post-processing: coefficients saturate just under +/-4.0
  logic [30:0]        q_sat;
  logic signed [31:0] coef_res, alpha_res;
  logic signed [32:0] a0_raw;
  assign q_sat     = (|div_quo[63:30]) ? 31'h3FFFFFFF : div_quo[30:0];
  assign coef_res  = div_neg ? -{1'b0, q_sat} : {1'b0, q_sat};
  assign alpha_res = div_neg ? -$signed(div_quo[31:0]) : $signed(div_quo[31:0]);
  assign a0_raw    = 33'sd268435456 + 33'(alpha_res);

  // phase in turns folded into +/- quarter turn
  logic signed [33:0] ang;
  assign ang = 34'($signed(div_quo[31:0]));

  // CORDIC rotation step
  logic signed [33:0] xsh, ysh, at;
  assign xsh = cx >>> iter;
  assign ysh = cy >>> iter;
  assign at  = 34'(eaw_pkg::atan_turn(5'(iter)));

  // trig rounding to the coefficient format
  logic signed [33:0] cfull, sfull, cround, sround;
  assign cfull  = trig_neg ? -cx : cx;
  assign sfull  = trig_neg ? -cy : cy;
  assign cround = (cfull + 34'sd2) >>> eaw_pkg::ROUND_SHIFT;
  assign sround = (sfull + 34'sd2) >>> eaw_pkg::ROUND_SHIFT;

  // envelope, filter and mix results
  logic [41:0]        env_sum;
  logic [25:0]        env_new;
  logic signed [37:0] y_full;
  logic signed [65:0] mix_sum;
  logic signed [49:0] mix_full;
  assign env_sum  = acc[41:0] + prod[41:0] + 42'd32768;
  assign env_new  = env_sum[41:16];
  assign y_full   = 38'(acc >>> eaw_pkg::COEF_FRAC_BITS);
  assign mix_sum  = acc + prod + 66'sd32768;
  assign mix_full = 50'(mix_sum >>> 16);

  // blend register: loads when the mix completes, clears when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == eaw_pkg::ST_MIX_ADD) && (!out_valid || blend.ready)) begin
      out_valid <= 1'b1;
    end else if (blend.valid && blend.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      env       <= '0;
      x1        <= '0;
      x2        <= '0;
      y1        <= '0;
      y2        <= '0;
      div_kind  <= eaw_pkg::DK_TURN;
    end else begin
      case (state)
        eaw_pkg::ST_IDLE:    if (audio.valid) x <= audio.dry_sample;
        eaw_pkg::ST_ENV_M1:  acc <= prod;
        eaw_pkg::ST_ENV_ADD: env <= (env_new > 26'(ENV_ONE)) ? ENV_ONE : env_new[SB-1:0];
        eaw_pkg::ST_FC_ADD: begin
          fc       <= {min_cutoff_hz, 16'b0} + 34'(prod[40:7]);
          div_kind <= eaw_pkg::DK_TURN;
        end
        eaw_pkg::ST_DIV_START: begin
          div_quo <= dnum[63] ? 64'(-dnum) : 64'(dnum);
          div_den <= dden[32] ? 32'(-dden) : dden[31:0];
          div_neg <= dnum[63] ^ dden[32];
          div_rem <= '0;
          div_cnt <= '0;
        end
        eaw_pkg::ST_DIV: begin
          div_rem <= div_rem_next;
          div_quo <= {div_quo[62:0], div_fits};
          div_cnt <= div_cnt + 6'd1;
        end
        eaw_pkg::ST_DIV_DONE: begin
          case (div_kind)
            eaw_pkg::DK_TURN: begin
              if (ang > 34'sd1073741824) begin
                cz       <= ang - 34'sd2147483648;
                trig_neg <= 1'b1;
              end else if (ang < -34'sd1073741824) begin
                cz       <= ang + 34'sd2147483648;
                trig_neg <= 1'b1;
              end else begin
                cz       <= ang;
                trig_neg <= 1'b0;
              end
              cx   <= eaw_pkg::CORDIC_GAIN;
              cy   <= '0;
              iter <= '0;
            end
            eaw_pkg::DK_ALPHA: begin
              alpha    <= alpha_res;
              a0       <= (a0_raw == 33'sd0) ? 33'sd1 : a0_raw;
              div_kind <= eaw_pkg::DK_B0;
            end
            eaw_pkg::DK_B0: begin
              b0       <= coef_res;
              div_kind <= eaw_pkg::DK_A1;
            end
            eaw_pkg::DK_A1: begin
              a1       <= coef_res;
              div_kind <= eaw_pkg::DK_A2;
            end
            default: a2 <= coef_res;
          endcase
        end
        eaw_pkg::ST_CORDIC: begin
          if (!cz[33]) begin
            cx <= cx - ysh;
            cy <= cy + xsh;
            cz <= cz - at;
          end else begin
            cx <= cx + ysh;
            cy <= cy - xsh;
            cz <= cz + at;
          end
          iter <= iter + IW'(1);
        end
        eaw_pkg::ST_TRIG: begin
          cs       <= 32'(cround);
          sn       <= 32'(sround);
          div_kind <= eaw_pkg::DK_ALPHA;
        end
        eaw_pkg::ST_FIR_M1: acc <= prod;
        eaw_pkg::ST_FIR_M2: acc <= acc + prod;
        eaw_pkg::ST_FIR_M3: acc <= acc + prod;
        eaw_pkg::ST_FIR_SUM: acc <= acc + prod + 66'sd134217728;
        eaw_pkg::ST_FIR_Y: begin
          if (y_full > 38'sd2147483647)       yv <= 32'sh7FFFFFFF;
          else if (y_full < -38'sd2147483648) yv <= 32'sh80000000;
          else                                yv <= y_full[31:0];
          if (y_full > 38'sd2147483647)       y1 <= 32'sh7FFFFFFF;
          else if (y_full < -38'sd2147483648) y1 <= 32'sh80000000;
          else                                y1 <= y_full[31:0];
          y2 <= y1;
          x1 <= x;
          x2 <= x1;
        end
        eaw_pkg::ST_MIX_M1: acc <= prod;
        eaw_pkg::ST_MIX_ADD: begin
          if (!out_valid || blend.ready) begin
            if (mix_full > 50'sd8388607)       out_sample <= 24'sh7FFFFF;
            else if (mix_full < -50'sd8388608) out_sample <= 24'sh800000;
            else                               out_sample <= mix_full[SB-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  assign blend.valid        = out_valid;
  assign blend.mixed_sample = out_sample;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  `EAW_ASSERT(a_env_clamped, env <= ENV_ONE)
  `EAW_ASSERT(a_div_rem_below_den, (state == eaw_pkg::ST_DIV) |-> (div_rem < div_den))
  `EAW_ASSERT(a_accept_starts, (audio.valid && audio.ready) |=> (state == eaw_pkg::ST_ENV_M0))
  `EAW_ASSERT(a_result_from_mix, $rose(out_valid) |-> ($past(state) == eaw_pkg::ST_MIX_ADD))
  `EAW_ASSERT_ALWAYS(a_reset_idle, $past(rst) |-> (state == eaw_pkg::ST_IDLE))

endmodule
